FILE: hdl/slcan_pkg.sv
// ----------------------------------------------------------------------------
// slcan_pkg
// Shared types, character codes and the hex digit decoder for the serial-line
// CAN text frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slcan_pkg;

  // Widths of the frame fields and of the parse state.
  localparam int CharW  = 8;
  localparam int IdW    = 29;
  localparam int LenW   = 4;
  localparam int DataW  = 64;
  localparam int NibW   = 4;
  localparam int NibN   = DataW / NibW;
  localparam int PosW   = 5;

  // Type characters.
  localparam logic [CharW-1:0] ChStdData = 8'h74;  // 't'
  localparam logic [CharW-1:0] ChExtData = 8'h54;  // 'T'
  localparam logic [CharW-1:0] ChStdRtr  = 8'h72;  // 'r'
  localparam logic [CharW-1:0] ChExtRtr  = 8'h52;  // 'R'

  // Digit ranges.
  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChUpA   = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChUpF   = 8'h46;  // 'F'
  localparam logic [CharW-1:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChLowF  = 8'h66;  // 'f'

  // Frame type codes: bit 0 is extended, bit 1 is request.
  localparam logic [1:0] FtStdData = 2'd0;
  localparam logic [1:0] FtExtData = 2'd1;
  localparam logic [1:0] FtStdRtr  = 2'd2;
  localparam logic [1:0] FtExtRtr  = 2'd3;

  // Positions and digit counts.
  localparam logic [PosW-1:0] PosFirst  = 5'd0;
  localparam logic [PosW-1:0] PosMax    = 5'd31;
  localparam logic [PosW-1:0] StdDigits = 5'd3;
  localparam logic [PosW-1:0] ExtDigits = 5'd8;
  localparam logic [NibW-1:0] MaxLen    = 4'd8;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic             status;
    logic             extended;
    logic             request;
    logic [IdW-1:0]   identifier;
    logic [LenW-1:0]  length;
    logic [DataW-1:0] payload;
  } out_word_t;

  // One finished frame handed from the parser to the output register.
  typedef struct packed {
    logic      load;
    out_word_t word;
  } frame_res_t;

  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] value;
  } hex_digit_t;

  // Decode one ASCII hex digit of either case.
  function automatic hex_digit_t hex_decode(input logic [CharW-1:0] c);
    hex_digit_t h;
    h.ok    = 1'b0;
    h.value = '0;
    if (c >= ChZero && c <= ChNine) begin
      h.ok    = 1'b1;
      h.value = NibW'(c - ChZero);
    end else if (c >= ChUpA && c <= ChUpF) begin
      h.ok    = 1'b1;
      h.value = NibW'(c - ChUpA + 8'd10);
    end else if (c >= ChLowA && c <= ChLowF) begin
      h.ok    = 1'b1;
      h.value = NibW'(c - ChLowA + 8'd10);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/slcan_ascii_frame_parser.sv
// ----------------------------------------------------------------------------
// slcan_ascii_frame_parser
// Serial-line CAN text frame parser: one ASCII character per word in, one
// decoded frame or format error out on the character marked last.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Word
//  input     in_valid, in_stall, in_word    character, end_of_frame
//  result    out_valid, out_stall, out_word status, extended, request,
//                                           identifier, length, payload
//
// A character word can be taken every cycle while in_stall is low. It is
// folded from the input register into the frame state, and a final character
// loads the result register at that same edge, so a result word passes through
// the input register and then the result register.
// Synchronous active-low reset empties both registers and clears the frame.
// A final character waits in the input register while the result register is
// full and stalled; other characters pass on regardless of out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_ascii_frame_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire slcan_pkg::in_word_t  in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output slcan_pkg::out_word_t      out_word
);
  import slcan_pkg::*;

  logic       in_valid_r;
  in_word_t   in_word_r;
  logic       out_free;
  logic       fire;
  frame_res_t res;

  // The held character moves on unless it closes a frame and the result is blocked.
  assign fire     = in_valid_r && (!in_word_r.end_of_frame || out_free);
  assign in_stall = in_valid_r && !fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
  end

  slcan_frame_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (in_word_r),
    .res   (res)
  );

  slcan_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

FILE: hdl/slcan_frame_state.sv
// ----------------------------------------------------------------------------
// slcan_frame_state
// Per-character parse state of the text frame and the decision made on the
// final character of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_frame_state (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire slcan_pkg::in_word_t   word,
  output slcan_pkg::frame_res_t      res
);
  import slcan_pkg::*;

  logic [PosW-1:0]           pos_r, pos_nxt;
  logic [1:0]                ftype_r, ftype_nxt;
  logic [IdW-1:0]            id_r, id_nxt;
  logic [LenW-1:0]           len_r, len_nxt;
  logic [NibN-1:0][NibW-1:0] data_r, data_nxt;
  logic                      err_r, err_nxt;

  hex_digit_t      hd;
  logic [PosW-1:0] id_digits;
  logic [PosW-1:0] id_digits_end;
  logic [PosW-1:0] data_pos;
  logic [PosW-1:0] expected;
  logic            bad;

  assign hd        = hex_decode(word.character);
  assign id_digits = ftype_r[0] ? ExtDigits : StdDigits;
  assign data_pos  = pos_r - id_digits - 5'd2;

  // Update the frame state with one character.
  always_comb begin
    pos_nxt   = pos_r;
    ftype_nxt = ftype_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    data_nxt  = data_r;
    err_nxt   = err_r;

    if (pos_r == PosFirst) begin
      unique case (word.character)
        ChStdData: ftype_nxt = FtStdData;
        ChExtData: ftype_nxt = FtExtData;
        ChStdRtr:  ftype_nxt = FtStdRtr;
        ChExtRtr:  ftype_nxt = FtExtRtr;
        default:   err_nxt   = 1'b1;
      endcase
    end else if (!err_r) begin
      if (pos_r <= id_digits) begin
        if (!hd.ok) begin
          err_nxt = 1'b1;
        end else begin
          id_nxt = {id_r[IdW-NibW-1:0], hd.value};
        end
      end else if (pos_r == id_digits + 5'd1) begin
        if (!hd.ok || hd.value > MaxLen) begin
          err_nxt = 1'b1;
        end else if (ftype_r[1] && hd.value != '0) begin
          err_nxt = 1'b1;
        end else begin
          len_nxt = hd.value;
        end
      end else begin
        if (data_pos >= {len_r, 1'b0} || data_pos[4] || !hd.ok) begin
          err_nxt = 1'b1;
        end else begin
          data_nxt[~data_pos[3:0]] = data_r[~data_pos[3:0]] | hd.value;
        end
      end
    end

    if (pos_r != PosMax) begin
      pos_nxt = pos_r + 5'd1;
    end
  end

  // Check the character count against the type and length of the frame, and form the result word.
  always_comb begin
    id_digits_end = ftype_nxt[0] ? ExtDigits : StdDigits;
    expected      = id_digits_end + 5'd2 + {len_nxt, 1'b0};
    bad           = err_nxt || (pos_nxt != expected);

    res.load = fire && word.end_of_frame;
    if (bad) begin
      res.word = '0;
      res.word.status = 1'b1;
    end else begin
      res.word.status     = 1'b0;
      res.word.extended   = ftype_nxt[0];
      res.word.request    = ftype_nxt[1];
      res.word.identifier = id_nxt;
      res.word.length     = len_nxt;
      res.word.payload    = data_nxt;
    end
  end

  // State registers; the final character starts a fresh frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ftype_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      data_r  <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      if (word.end_of_frame) begin
        pos_r   <= '0;
        ftype_r <= '0;
        id_r    <= '0;
        len_r   <= '0;
        data_r  <= '0;
        err_r   <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        ftype_r <= ftype_nxt;
        id_r    <= id_nxt;
        len_r   <= len_nxt;
        data_r  <= data_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/slcan_out_reg.sv
// ----------------------------------------------------------------------------
// slcan_out_reg
// Result register that holds a parsed frame until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire slcan_pkg::frame_res_t res,
  output logic                       free,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output slcan_pkg::out_word_t       out_word
);
  import slcan_pkg::*;

  logic      valid_r;
  out_word_t word_r;

  // The register can take a new word when empty or when its word leaves now.
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= res.load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res.load) begin
      word_r <= res.word;
    end
  end

endmodule

`default_nettype wire
